>>> rtl/ogru_pkg.sv
package ogru_pkg;

    localparam int COORD_W = 9;
    localparam int SCORE_W = 16;
    localparam int GAIN_W  = 15;
    localparam int GUARD_W = 10;
    localparam int CLASS_W = 2;
    localparam int REQ_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W   = 16;

    localparam logic [REQ_W-1:0] REQ_BEAM  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE  = 2'd3;

    localparam logic [CLASS_W-1:0] CLASS_FREE     = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_UNKNOWN  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_OCCUPIED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HIT_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_LOSS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OCC_LEVEL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_LEVEL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SUPPORT_GAIN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_GUARD        = 3'd7;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic               valid_beam;
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] ey;
        logic               hit;
        logic               read_ok;
        logic [COORD_W-1:0] rx;
        logic [COORD_W-1:0] ry;
    } t_cmd;

    typedef struct packed {
        logic [GAIN_W-1:0]         hit_gain;
        logic [GAIN_W-1:0]         free_loss;
        logic signed [SCORE_W-1:0] occ_level;
        logic signed [SCORE_W-1:0] free_level;
        logic signed [SCORE_W-1:0] floor_v;
        logic signed [SCORE_W-1:0] ceil_v;
        logic [GAIN_W-1:0]         support_gain;
        logic [GUARD_W-1:0]        guard;
    } t_cfg;

endpackage

>>> rtl/ogru_front.sv
module ogru_front
    import ogru_pkg::*;
#(
    parameter int GRID_WIDTH  = 512,
    parameter int GRID_HEIGHT = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [REQ_W-1:0]      i_req,
    input  logic [COORD_W-1:0]    i_sx,
    input  logic [COORD_W-1:0]    i_sy,
    input  logic [COORD_W-1:0]    i_ex,
    input  logic [COORD_W-1:0]    i_ey,
    input  logic                  i_hit,
    input  logic [COORD_W-1:0]    i_rx,
    input  logic [COORD_W-1:0]    i_ry,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_pop,
    output t_cmd                  o_cmd
);
    localparam int DEPTH = 2;

    t_cmd       r_q [DEPTH];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cmd       n_cmd;
    logic       push, pop;

    function automatic logic in_grid(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y);
        in_grid = (32'(x) < GRID_WIDTH) && (32'(y) < GRID_HEIGHT);
    endfunction

    always_comb begin
        n_cmd            = '0;
        n_cmd.req        = i_req;
        n_cmd.valid_beam = in_grid(i_sx, i_sy) && in_grid(i_ex, i_ey);
        n_cmd.sx         = i_sx;
        n_cmd.sy         = i_sy;
        n_cmd.ex         = i_ex;
        n_cmd.ey         = i_ey;
        n_cmd.hit        = i_hit;
        n_cmd.read_ok    = in_grid(i_rx, i_ry);
        n_cmd.rx         = i_rx;
        n_cmd.ry         = i_ry;
    end

    assign o_ready     = i_rst_n && (r_cnt != 2'(DEPTH));
    assign push        = i_valid && o_ready && (i_req != REQ_NONE);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= n_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

>>> rtl/ogru_back.sv
module ogru_back
    import ogru_pkg::*;
#(
    parameter int GRID_WIDTH  = 512,
    parameter int GRID_HEIGHT = 512,
    parameter int NBR_RADIUS  = 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cfg                      i_cfg,
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_pop,
    input  t_cmd                      i_cmd,
    output logic                      o_res_valid,
    input  logic                      i_res_ready,
    output logic [REQ_W-1:0]          o_kind,
    output logic signed [SCORE_W-1:0] o_score,
    output logic [CLASS_W-1:0]        o_class
);
    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int SW    = 14;

    localparam logic [3:0] S_CLR_INIT = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_WALK     = 4'd2;
    localparam logic [3:0] S_RD       = 4'd3;
    localparam logic [3:0] S_MOD      = 4'd4;
    localparam logic [3:0] S_WR       = 4'd5;
    localparam logic [3:0] S_NEXT     = 4'd6;
    localparam logic [3:0] S_READ1    = 4'd7;
    localparam logic [3:0] S_READ2    = 4'd8;
    localparam logic [3:0] S_CLEAR    = 4'd9;
    localparam logic [3:0] S_OUT      = 4'd10;

    localparam logic [1:0] PH_WALK = 2'd0;
    localparam logic [1:0] PH_HIT  = 2'd1;
    localparam logic [1:0] PH_SUP  = 2'd2;

    logic signed [SCORE_W-1:0] r_score_mem [CELLS];
    logic [CLASS_W-1:0]        r_class_mem [CELLS];

    logic [3:0]                r_st;
    logic [1:0]                r_ph;
    t_cmd                      r_cmd;
    logic signed [SW-1:0]      r_x, r_y, r_err, r_dx, r_dy;
    logic signed [SW-1:0]      r_cx, r_cy;
    logic signed [4:0]         r_ox, r_oy;
    logic signed [17:0]        r_delta;
    logic [AW-1:0]             r_addr;
    logic [AW:0]               r_clr;
    logic signed [SCORE_W-1:0] r_rd_score;
    logic [CLASS_W-1:0]        r_rd_class;
    logic signed [SCORE_W-1:0] r_new_score;
    logic [CLASS_W-1:0]        r_new_class;
    logic                      r_res_valid;
    logic [REQ_W-1:0]          r_kind;
    logic signed [SCORE_W-1:0] r_oscore;
    logic [CLASS_W-1:0]        r_oclass;

    logic signed [SW-1:0] ex, ey, ddx, ddy, cheb, e2, stx, sty;
    logic signed [SW-1:0] cx2, cy2, n_dx, n_dy;
    logic signed [4:0]    nox, noy;
    logic                 cin, sup_last;
    logic signed [17:0]   sum, clamped;
    logic [CLASS_W-1:0]   cls;

    logic                      clearing, mem_we;
    logic [AW-1:0]             cell_addr, mem_raddr, mem_waddr;
    logic signed [SCORE_W-1:0] mem_wscore;
    logic [CLASS_W-1:0]        mem_wclass;

    assign ex   = SW'(r_cmd.ex);
    assign ey   = SW'(r_cmd.ey);
    assign ddx  = (ex > r_x) ? ex - r_x : r_x - ex;
    assign ddy  = (ey > r_y) ? ey - r_y : r_y - ey;
    assign cheb = (ddx > ddy) ? ddx : ddy;
    assign e2   = r_err <<< 1;
    assign stx  = (r_x < ex) ? SW'(1) : -SW'(1);
    assign sty  = (r_y < ey) ? SW'(1) : -SW'(1);

    assign n_dx = (i_cmd.ex > i_cmd.sx) ? SW'(i_cmd.ex - i_cmd.sx) : SW'(i_cmd.sx - i_cmd.ex);
    assign n_dy = (i_cmd.ey > i_cmd.sy) ? SW'(i_cmd.ey - i_cmd.sy) : SW'(i_cmd.sy - i_cmd.ey);

    always_comb begin
        nox = r_ox + 5'sd1;
        noy = r_oy;
        if (r_ox == 5'(NBR_RADIUS)) begin
            nox = -5'(NBR_RADIUS);
            noy = r_oy + 5'sd1;
        end
        if (nox == 5'sd0 && noy == 5'sd0) begin
            nox = 5'sd1;
        end
        sup_last = (r_ox == 5'(NBR_RADIUS)) && (r_oy == 5'(NBR_RADIUS));
        cx2 = ex + SW'(nox);
        cy2 = ey + SW'(noy);
    end

    assign cin = (r_cx >= 0) && (r_cy >= 0) && (r_cx < SW'(GRID_WIDTH))
              && (r_cy < SW'(GRID_HEIGHT));

    always_comb begin
        sum = 18'(r_rd_score) + r_delta;
        clamped = sum;
        if (clamped < 18'(i_cfg.floor_v)) begin
            clamped = 18'(i_cfg.floor_v);
        end
        if (clamped > 18'(i_cfg.ceil_v)) begin
            clamped = 18'(i_cfg.ceil_v);
        end
        if (clamped >= 18'(i_cfg.occ_level)) begin
            cls = CLASS_OCCUPIED;
        end else if (clamped <= 18'(i_cfg.free_level)) begin
            cls = CLASS_FREE;
        end else begin
            cls = CLASS_UNKNOWN;
        end
    end

    assign cell_addr  = AW'(r_cy[YW-1:0]) * AW'(GRID_WIDTH) + AW'(r_cx[XW-1:0]);
    assign mem_raddr  = (r_st == S_READ1) ? r_addr : cell_addr;
    assign clearing   = (r_st == S_CLR_INIT) || (r_st == S_CLEAR);
    assign mem_we     = clearing || (r_st == S_WR);
    assign mem_waddr  = clearing ? r_clr[AW-1:0] : r_addr;
    assign mem_wscore = clearing ? '0 : r_new_score;
    assign mem_wclass = clearing ? CLASS_UNKNOWN : r_new_class;

    assign o_cmd_pop   = (r_st == S_IDLE) && i_cmd_valid && !r_res_valid;
    assign o_res_valid = r_res_valid;
    assign o_kind      = r_kind;
    assign o_score     = r_oscore;
    assign o_class     = r_oclass;

    always_ff @(posedge i_clk) begin
        if (r_st == S_RD || r_st == S_READ1) begin
            r_rd_score <= r_score_mem[mem_raddr];
            r_rd_class <= r_class_mem[mem_raddr];
        end
        if (mem_we) begin
            r_score_mem[mem_waddr] <= mem_wscore;
            r_class_mem[mem_waddr] <= mem_wclass;
        end
        if (r_st == S_MOD) begin
            r_new_score <= clamped[SCORE_W-1:0];
            r_new_class <= cls;
        end
        if (o_cmd_pop) begin
            r_cmd  <= i_cmd;
            r_x    <= SW'(i_cmd.sx);
            r_y    <= SW'(i_cmd.sy);
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_err  <= n_dx - n_dy;
            r_addr <= AW'(i_cmd.ry) * AW'(GRID_WIDTH) + AW'(i_cmd.rx);
        end
        if (r_st == S_RD) begin
            r_addr <= cell_addr;
        end
        if (!i_rst_n) begin
            r_st        <= S_CLR_INIT;
            r_clr       <= '0;
            r_res_valid <= 1'b0;
            r_ph        <= PH_WALK;
        end else begin
            if (r_res_valid && i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            case (r_st)
                S_CLR_INIT, S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (AW+1)'(CELLS - 1)) begin
                        r_st <= (r_st == S_CLEAR) ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_ph <= PH_WALK;
                        if (i_cmd.req == REQ_READ) begin
                            r_st <= i_cmd.read_ok ? S_READ1 : S_OUT;
                        end else if (i_cmd.req == REQ_CLEAR) begin
                            r_clr <= '0;
                            r_st  <= S_CLEAR;
                        end else if (i_cmd.valid_beam) begin
                            r_st <= S_WALK;
                        end else begin
                            r_st <= S_OUT;
                        end
                    end
                end
                S_WALK: begin
                    if (r_x == ex && r_y == ey) begin
                        if (r_cmd.hit) begin
                            r_ph    <= PH_HIT;
                            r_cx    <= ex;
                            r_cy    <= ey;
                            r_delta <= 18'(i_cfg.hit_gain);
                            r_st    <= S_RD;
                        end else begin
                            r_st <= S_OUT;
                        end
                    end else begin
                        r_cx    <= r_x;
                        r_cy    <= r_y;
                        r_delta <= -18'(i_cfg.free_loss);
                        if (e2 > -r_dy) begin
                            r_x <= r_x + stx;
                        end
                        if (e2 < r_dx) begin
                            r_y <= r_y + sty;
                        end
                        r_err <= r_err - ((e2 > -r_dy) ? r_dy : SW'(0))
                                       + ((e2 < r_dx) ? r_dx : SW'(0));
                        if (cheb > SW'(i_cfg.guard)) begin
                            r_st <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_st <= cin ? S_MOD : S_NEXT;
                end
                S_MOD: r_st <= S_WR;
                S_WR:  r_st <= S_NEXT;
                S_NEXT: begin
                    if (r_ph == PH_WALK) begin
                        r_st <= S_WALK;
                    end else if (r_ph == PH_HIT) begin
                        if (NBR_RADIUS == 0 || i_cfg.support_gain == '0) begin
                            r_st <= S_OUT;
                        end else begin
                            r_ph    <= PH_SUP;
                            r_ox    <= -5'(NBR_RADIUS);
                            r_oy    <= -5'(NBR_RADIUS);
                            r_cx    <= ex - SW'(NBR_RADIUS);
                            r_cy    <= ey - SW'(NBR_RADIUS);
                            r_delta <= 18'(i_cfg.support_gain);
                            r_st    <= S_RD;
                        end
                    end else if (sup_last) begin
                        r_st <= S_OUT;
                    end else begin
                        r_ox <= nox;
                        r_oy <= noy;
                        r_cx <= cx2;
                        r_cy <= cy2;
                        r_st <= S_RD;
                    end
                end
                S_READ1: r_st <= S_READ2;
                S_READ2: r_st <= S_OUT;
                S_OUT: begin
                    if (!r_res_valid) begin
                        r_res_valid <= 1'b1;
                        r_kind      <= r_cmd.req;
                        r_oscore    <= '0;
                        r_oclass    <= CLASS_FREE;
                        if (r_cmd.req == REQ_READ) begin
                            r_oscore <= r_cmd.read_ok ? r_rd_score : '0;
                            r_oclass <= r_cmd.read_ok ? r_rd_class : CLASS_UNKNOWN;
                        end
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/occupancy_grid_ray_update.sv
// A clear rewrites every cell; a beam walks its line, updating each cell beyond the guard
// distance from the end cell, then, on a hit, the end cell and its in-grid neighbors.
// Throughput: one item at a time; the next starts once the previous result is taken.
// Reset (synchronous, active low) loads register defaults and runs a clearing pass over
// all GRID_WIDTH*GRID_HEIGHT cells; up to two items queue meanwhile.
module occupancy_grid_ray_update
    import ogru_pkg::*;
#(
    parameter int GRID_WIDTH  = 512,
    parameter int GRID_HEIGHT = 512,
    parameter int NBR_RADIUS  = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // ray_start_x, ray_start_y, ray_end_x, ray_end_y, beam_hit, read_x, read_y
    input  logic [55:0]          s_axis_tdata,
    // req_type
    input  logic [REQ_W-1:0]     s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // cell_score_out, cell_class_out
    output logic [23:0]          m_axis_tdata,
    // reply_kind
    output logic [REQ_W-1:0]     m_axis_tuser,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);
    t_cfg r_cfg;
    t_cmd cmd;
    logic cmd_valid, cmd_pop, q_ready;
    logic signed [SCORE_W-1:0] score;
    logic [CLASS_W-1:0] cls;

    assign s_axis_tready = q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hit_gain     <= 15'd20;
            r_cfg.free_loss    <= 15'd3;
            r_cfg.occ_level    <= 16'sd20;
            r_cfg.free_level   <= -16'sd5;
            r_cfg.floor_v      <= -16'sd20;
            r_cfg.ceil_v       <= 16'sd100;
            r_cfg.support_gain <= 15'd8;
            r_cfg.guard        <= 10'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HIT_GAIN:     r_cfg.hit_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_FREE_LOSS:    r_cfg.free_loss    <= i_cfg_data[GAIN_W-1:0];
                CFG_OCC_LEVEL:    r_cfg.occ_level    <= i_cfg_data;
                CFG_FREE_LEVEL:   r_cfg.free_level   <= i_cfg_data;
                CFG_FLOOR:        r_cfg.floor_v      <= i_cfg_data;
                CFG_CEILING:      r_cfg.ceil_v       <= i_cfg_data;
                CFG_SUPPORT_GAIN: r_cfg.support_gain <= i_cfg_data[GAIN_W-1:0];
                CFG_GUARD:        r_cfg.guard        <= i_cfg_data[GUARD_W-1:0];
                default: ;
            endcase
        end
    end

    ogru_front #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(q_ready),
        .i_req(s_axis_tuser), .i_sx(s_axis_tdata[8:0]), .i_sy(s_axis_tdata[17:9]),
        .i_ex(s_axis_tdata[26:18]), .i_ey(s_axis_tdata[35:27]), .i_hit(s_axis_tdata[36]),
        .i_rx(s_axis_tdata[45:37]), .i_ry(s_axis_tdata[54:46]),
        .o_cmd_valid(cmd_valid), .i_cmd_pop(cmd_pop), .o_cmd(cmd)
    );

    ogru_back #(.GRID_WIDTH(GRID_WIDTH), .GRID_HEIGHT(GRID_HEIGHT),
                .NBR_RADIUS(NBR_RADIUS)) u_back (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_cmd_valid(cmd_valid), .o_cmd_pop(cmd_pop), .i_cmd(cmd),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .o_kind(m_axis_tuser), .o_score(score), .o_class(cls)
    );

    assign m_axis_tdata = {6'd0, cls, score};
endmodule

>>> tb/tb_occupancy_grid_ray_update.sv
module tb_occupancy_grid_ray_update;
    import ogru_pkg::*;

    localparam int GW = 512;
    localparam int GH = 512;
    localparam int RADIUS = 1;
    localparam int CELLS = GW * GH;
    localparam int SETTLE = 3000;

    typedef struct {
        logic [REQ_W-1:0]   req;
        logic [COORD_W-1:0] sx, sy, ex, ey;
        logic               hit;
        logic [COORD_W-1:0] rx, ry;
    } t_req_item;

    typedef struct {
        logic [REQ_W-1:0]          kind;
        logic signed [SCORE_W-1:0] score;
        logic [CLASS_W-1:0]        cls;
    } t_reply;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [55:0]          s_axis_tdata;
    logic [REQ_W-1:0]     s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [23:0]          m_axis_tdata;
    logic [REQ_W-1:0]     m_axis_tuser;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    occupancy_grid_ray_update i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    t_req_item pending_q[$];
    t_reply    reply_q[$];
    t_req_item cur_item;
    int        errors = 0;
    bit        in_taken = 0;
    bit        no_idle = 0;
    int        send_gap = 0;
    int        recv_stall = 0;

    logic signed [SCORE_W-1:0] score_mem [CELLS];
    logic [CLASS_W-1:0]        class_mem [CELLS];
    int hit_gain, free_loss, occ_level, free_level, floor_v, ceil_v, support_gain, guard;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #(64'd20 * 64'd20_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void wipe_grid();
        for (int i = 0; i < CELLS; i++) begin
            score_mem[i] = '0;
            class_mem[i] = CLASS_UNKNOWN;
        end
    endfunction

    function automatic void bump_cell(int x, int y, int delta);
        int idx;
        int v;
        if (x < 0 || y < 0 || x >= GW || y >= GH) return;
        idx = y * GW + x;
        v = int'(score_mem[idx]) + delta;
        if (v < floor_v) v = floor_v;
        if (v > ceil_v) v = ceil_v;
        score_mem[idx] = v[15:0];
        if (v >= occ_level) class_mem[idx] = CLASS_OCCUPIED;
        else if (v <= free_level) class_mem[idx] = CLASS_FREE;
        else class_mem[idx] = CLASS_UNKNOWN;
    endfunction

    function automatic void trace_beam(int sx, int sy, int ex, int ey);
        int x, y, dx, dy, stx, sty, err, e2, ddx, ddy, cheb;
        x = sx; y = sy;
        dx = (ex > sx) ? ex - sx : sx - ex;
        dy = (ey > sy) ? ey - sy : sy - ey;
        stx = (sx < ex) ? 1 : -1;
        sty = (sy < ey) ? 1 : -1;
        err = dx - dy;
        while (x != ex || y != ey) begin
            ddx = (ex > x) ? ex - x : x - ex;
            ddy = (ey > y) ? ey - y : y - ey;
            cheb = (ddx > ddy) ? ddx : ddy;
            e2 = 2 * err;
            if (cheb > guard) bump_cell(x, y, -free_loss);
            if (e2 > -dy) begin
                err -= dy;
                x += stx;
            end
            if (e2 < dx) begin
                err += dx;
                y += sty;
            end
        end
    endfunction

    function automatic bit on_grid(int x, int y);
        return x >= 0 && y >= 0 && x < GW && y < GH;
    endfunction

    function automatic void predict_reply(t_req_item it);
        t_reply r;
        int idx;
        r.kind = it.req;
        r.score = '0;
        r.cls = '0;
        case (it.req)
            REQ_BEAM: begin
                if (on_grid(int'(it.sx), int'(it.sy)) && on_grid(int'(it.ex), int'(it.ey))) begin
                    trace_beam(int'(it.sx), int'(it.sy), int'(it.ex), int'(it.ey));
                    if (it.hit) begin
                        bump_cell(int'(it.ex), int'(it.ey), hit_gain);
                        if (RADIUS != 0 && support_gain != 0)
                            for (int oy = -RADIUS; oy <= RADIUS; oy++)
                                for (int ox = -RADIUS; ox <= RADIUS; ox++)
                                    if (ox != 0 || oy != 0)
                                        bump_cell(int'(it.ex) + ox, int'(it.ey) + oy,
                                                  support_gain);
                    end
                end
                reply_q.push_back(r);
            end
            REQ_READ: begin
                if (on_grid(int'(it.rx), int'(it.ry))) begin
                    idx = int'(it.ry) * GW + int'(it.rx);
                    r.score = score_mem[idx];
                    r.cls = class_mem[idx];
                end else begin
                    r.cls = CLASS_UNKNOWN;
                end
                reply_q.push_back(r);
            end
            REQ_CLEAR: begin
                wipe_grid();
                reply_q.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic logic [55:0] pack_item(t_req_item it);
        return {1'b0, it.ry, it.rx, it.hit, it.ey, it.ex, it.sy, it.sx};
    endfunction

    function automatic logic [8:0] near(int c);
        int v;
        v = c + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > 511) v = 511;
        return v[8:0];
    endfunction

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !in_taken) begin
        end else begin
            if (in_taken) begin
                in_taken = 0;
                send_gap = no_idle ? 0 : int'($urandom_range(0, 13));
            end
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                cur_item = pending_q.pop_front();
                s_axis_tdata <= pack_item(cur_item);
                s_axis_tuser <= cur_item.req;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        if (recv_stall > 0) begin
            recv_stall--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_reply e;
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            in_taken = 1;
            predict_reply(cur_item);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            recv_stall = no_idle ? 0 : int'($urandom_range(0, 13));
            if (reply_q.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual %h %h",
                         $time, m_axis_tuser, m_axis_tdata);
                errors++;
            end else begin
                e = reply_q.pop_front();
                if (m_axis_tuser !== e.kind) begin
                    $display("%0t: reply_kind expected %0d actual %0d",
                             $time, e.kind, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[15:0] !== e.score) begin
                    $display("%0t: cell_score_out expected %0d actual %0d",
                             $time, e.score, $signed(m_axis_tdata[15:0]));
                    errors++;
                end
                if (m_axis_tdata[17:16] !== e.cls) begin
                    $display("%0t: cell_class_out expected %0d actual %0d",
                             $time, e.cls, m_axis_tdata[17:16]);
                    errors++;
                end
            end
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int value);
        logic [15:0] v;
        v = value[15:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_HIT_GAIN:     hit_gain = int'(v[14:0]);
            CFG_FREE_LOSS:    free_loss = int'(v[14:0]);
            CFG_OCC_LEVEL:    occ_level = int'($signed(v));
            CFG_FREE_LEVEL:   free_level = int'($signed(v));
            CFG_FLOOR:        floor_v = int'($signed(v));
            CFG_CEILING:      ceil_v = int'($signed(v));
            CFG_SUPPORT_GAIN: support_gain = int'(v[14:0]);
            CFG_GUARD:        guard = int'(v[9:0]);
            default: ;
        endcase
    endtask

    task automatic load_regs(int hg, int fl, int ol, int fv, int lo, int hi, int sg, int gd);
        cfg_write(CFG_HIT_GAIN, hg);
        cfg_write(CFG_FREE_LOSS, fl);
        cfg_write(CFG_OCC_LEVEL, ol);
        cfg_write(CFG_FREE_LEVEL, fv);
        cfg_write(CFG_FLOOR, lo);
        cfg_write(CFG_CEILING, hi);
        cfg_write(CFG_SUPPORT_GAIN, sg);
        cfg_write(CFG_GUARD, gd);
    endtask

    task automatic wait_drained();
        while (pending_q.size() > 0 || s_axis_tvalid || reply_q.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    function automatic void add_item(logic [1:0] req, int sx, int sy, int ex, int ey,
                                     bit hit, int rx, int ry);
        t_req_item it;
        it.req = req;
        it.sx = COORD_W'(sx); it.sy = COORD_W'(sy);
        it.ex = COORD_W'(ex); it.ey = COORD_W'(ey);
        it.hit = hit; it.rx = COORD_W'(rx); it.ry = COORD_W'(ry);
        pending_q.push_back(it);
    endfunction

    function automatic void add_random(int n);
        t_req_item it;
        int hx, hy, pick;
        hx = 0; hy = 0;
        for (int i = 0; i < n; i++) begin
            if (i % 20 == 0) begin
                pick = $urandom_range(0, 3);
                hx = (pick == 0) ? 0 : (pick == 1) ? 511 : $urandom_range(0, 511);
                hy = (pick == 0) ? 511 : (pick == 1) ? 0 : $urandom_range(0, 511);
            end
            it.sx = COORD_W'($urandom); it.sy = COORD_W'($urandom);
            it.ex = COORD_W'($urandom); it.ey = COORD_W'($urandom);
            it.rx = COORD_W'($urandom); it.ry = COORD_W'($urandom);
            it.hit = 1'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                it.req = REQ_BEAM;
                it.sx = near(hx); it.sy = near(hy); it.ex = near(hx); it.ey = near(hy);
            end else if (pick < 60) begin
                it.req = REQ_BEAM;
            end else if (pick < 90) begin
                it.req = REQ_READ;
                it.rx = near(hx); it.ry = near(hy);
            end else if (pick < 97) begin
                it.req = REQ_READ;
            end else begin
                it.req = REQ_NONE;
            end
            pending_q.push_back(it);
        end
    endfunction

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        hit_gain = 20; free_loss = 3; occ_level = 20; free_level = -5;
        floor_v = -20; ceil_v = 100; support_gain = 8; guard = 1;
        wipe_grid();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        add_item(REQ_BEAM, 10, 10, 10, 10, 1, 0, 0);
        add_item(REQ_READ, 0, 0, 0, 0, 0, 10, 10);
        add_item(REQ_READ, 0, 0, 0, 0, 0, 11, 11);
        add_item(REQ_BEAM, 0, 0, 511, 511, 1, 0, 0);
        add_item(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
        add_item(REQ_READ, 0, 0, 0, 0, 0, 511, 511);
        add_item(REQ_READ, 0, 0, 0, 0, 0, 510, 511);
        add_item(REQ_BEAM, 511, 0, 0, 0, 0, 0, 0);
        add_item(REQ_READ, 0, 0, 0, 0, 0, 300, 0);
        add_item(REQ_BEAM, 5, 500, 9, 0, 1, 0, 0);
        add_item(REQ_READ, 0, 0, 0, 0, 0, 8, 1);
        add_item(REQ_BEAM, 20, 20, 21, 21, 1, 0, 0);
        add_item(REQ_READ, 0, 0, 0, 0, 0, 20, 20);
        add_item(REQ_NONE, 511, 511, 511, 511, 1, 511, 511);
        add_item(REQ_BEAM, 0, 511, 511, 0, 0, 0, 0);
        add_item(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        add_item(REQ_READ, 0, 0, 0, 0, 0, 511, 511);
        add_item(REQ_READ, 0, 0, 0, 0, 0, 10, 10);
        add_random(130);
        wait_drained();

        no_idle = 1;
        load_regs(32767, 32767, 32767, -32768, -32768, 32767, 0, 0);
        add_item(REQ_BEAM, 100, 100, 100, 100, 1, 0, 0);
        add_item(REQ_BEAM, 100, 100, 100, 100, 1, 0, 0);
        add_item(REQ_READ, 0, 0, 0, 0, 0, 100, 100);
        add_random(110);
        wait_drained();

        no_idle = 0;
        load_regs(0, 1, -32768, 32767, 50, 10, 32767, 1023);
        add_random(110);
        wait_drained();

        load_regs($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom);
        add_random(110);
        wait_drained();

        load_regs(5, 2, 10, -3, -30, 40, 3, 2);
        add_random(110);
        wait_drained();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/ogru_pkg.sv
rtl/ogru_front.sv
rtl/ogru_back.sv
rtl/occupancy_grid_ray_update.sv
tb/tb_occupancy_grid_ray_update.sv
